// File: design/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);

  // Every block start is a multiple of the largest power of two that divides
  // both the header size and the alignment, so the header store is indexed
  // in units of that granule.
  localparam int GRAN_BITS = HEADER_BYTES | ALIGN_BYTES;
  localparam int GRAN = GRAN_BITS & (-GRAN_BITS);
  localparam int GRAN_SHIFT = $clog2(GRAN);

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;

  localparam logic [0:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [0:0] CFG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] request_bytes;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic re;
    logic size_we;
    logic free_we;
  } mem_ctl_t;

endpackage
`default_nettype wire

// File: design/ffha_hdr_mem.sv
`default_nettype none
module ffha_hdr_mem #(
  parameter int HEAP_BYTES = 65536
) (
  input wire logic clk,
  input wire ffha_pkg::mem_ctl_t ctl,
  input wire logic [$clog2((HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN)-1:0] raddr,
  input wire logic [$clog2((HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN)-1:0] waddr,
  input wire logic [$clog2(HEAP_BYTES + 1)-1:0] wsize,
  input wire logic wfree,
  output logic [$clog2(HEAP_BYTES + 1)-1:0] rd_size,
  output logic rd_free
);

  localparam int DEPTH = (HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN;
  localparam int OFF_W = $clog2(HEAP_BYTES + 1);

  logic [OFF_W-1:0] size_mem [DEPTH];
  logic free_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.size_we) begin
      size_mem[waddr] <= wsize;
    end
    if (ctl.free_we) begin
      free_mem[waddr] <= wfree;
    end
    if (ctl.re) begin
      rd_size <= size_mem[raddr];
      rd_free <= free_mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/ffha_engine.sv
`default_nettype none
module ffha_engine #(
  parameter int HEAP_BYTES = 65536
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [31:0] heap_base,
  input wire logic [16:0] heap_bytes,
  input wire logic cmd_valid,
  input wire ffha_pkg::in_item_t cmd,
  output logic busy,
  output logic res_valid,
  output ffha_pkg::out_item_t res,
  input wire logic res_take,
  output ffha_pkg::mem_ctl_t mem_ctl,
  output logic [$clog2((HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN)-1:0] mem_raddr,
  output logic [$clog2((HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN)-1:0] mem_waddr,
  output logic [$clog2(HEAP_BYTES + 1)-1:0] mem_wsize,
  output logic mem_wfree,
  input wire logic [$clog2(HEAP_BYTES + 1)-1:0] rd_size,
  input wire logic rd_free
);

  localparam int DEPTH = (HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int OFF_W = $clog2(HEAP_BYTES + 1);
  localparam int AW = ((OFF_W > 17) ? OFF_W : 17) + 2;
  localparam int GSH = ffha_pkg::GRAN_SHIFT;
  localparam int HDR = ffha_pkg::HEADER_BYTES;
  localparam int ALN = ffha_pkg::ALIGN_BYTES;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ACHK   = 7'b0000010,
    ST_ATAKE  = 7'b0000100,
    ST_FSTART = 7'b0001000,
    ST_FCUR   = 7'b0010000,
    ST_FNXT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic ready_r, ready_nxt;
  logic [31:0] abase_r, abase_nxt;
  logic [OFF_W-1:0] ue_r, ue_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [16:0] need_r, need_nxt;
  logic split_r, split_nxt;
  logic [OFF_W-1:0] cur_r, cur_nxt;
  logic [OFF_W-1:0] cur_size_r, cur_size_nxt;
  logic cur_free_r, cur_free_nxt;
  logic [OFF_W-1:0] nxt_r, nxt_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic res_fail_r, res_fail_nxt;

  logic [32:0] base33, bytes33, abase33, pad33;
  logic init_rej;
  logic [OFF_W-1:0] ue_init;
  logic [16:0] need_init;
  logic [32:0] addr33, lo33, off33;
  logic free_bad;
  logic [AW-1:0] sz_a, off_a, need_a, ue_a, nb_a, end_a, f1_a, n2_a, merge_a;
  logic fit, do_split;

  always_comb begin
    base33 = {1'b0, heap_base};
    bytes33 = {16'd0, heap_bytes};
    abase33 = (base33 + 33'(ALN - 1)) & ~33'(ALN - 1);
    pad33 = abase33 - base33;
    init_rej = (heap_base == 32'd0) || (bytes33 <= 33'(HDR + ALN)) ||
               (bytes33 > 33'(HEAP_BYTES)) || (base33 + bytes33 > 33'h1_0000_0000) ||
               (pad33 + 33'(HDR) > bytes33);
    ue_init = OFF_W'(bytes33 - pad33);
    need_init = (({1'b0, cmd.request_bytes} + 17'(ALN - 1)) >> ffha_pkg::ALIGN_SHIFT)
                << ffha_pkg::ALIGN_SHIFT;
    addr33 = {1'b0, cmd.address};
    lo33 = {1'b0, abase_r} + 33'(HDR);
    off33 = addr33 - lo33;
    free_bad = !ready_r || (addr33 < lo33) || (off33 + 33'(HDR) > 33'(ue_r));
    sz_a = AW'(rd_size);
    off_a = AW'(off_r);
    need_a = AW'(need_r);
    ue_a = AW'(ue_r);
    fit = rd_free && (sz_a >= need_a);
    nb_a = off_a + AW'(HDR) + need_a;
    do_split = (sz_a >= need_a + AW'(HDR + ALN)) && (nb_a < ue_a);
    end_a = off_a + AW'(HDR) + sz_a;
    f1_a = AW'(HDR) + sz_a;
    n2_a = AW'(nxt_r) + AW'(HDR) + sz_a;
    merge_a = AW'(cur_size_r) + AW'(HDR) + sz_a;
  end

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    abase_nxt = abase_r;
    ue_nxt = ue_r;
    off_nxt = off_r;
    need_nxt = need_r;
    split_nxt = split_r;
    cur_nxt = cur_r;
    cur_size_nxt = cur_size_r;
    cur_free_nxt = cur_free_r;
    nxt_nxt = nxt_r;
    res_addr_nxt = res_addr_r;
    res_fail_nxt = res_fail_r;
    mem_ctl = '0;
    mem_raddr = '0;
    mem_waddr = '0;
    mem_wsize = '0;
    mem_wfree = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          res_addr_nxt = 32'd0;
          res_fail_nxt = 1'b1;
          state_nxt = ST_DONE;
          case (cmd.command)
            ffha_pkg::CMD_INIT: begin
              if (!init_rej) begin
                ready_nxt = 1'b1;
                abase_nxt = abase33[31:0];
                ue_nxt = ue_init;
                mem_ctl.size_we = 1'b1;
                mem_ctl.free_we = 1'b1;
                mem_wsize = ue_init - OFF_W'(HDR);
                mem_wfree = 1'b1;
                res_fail_nxt = 1'b0;
              end
            end
            ffha_pkg::CMD_ALLOC: begin
              if (ready_r && (cmd.request_bytes != 16'd0)) begin
                need_nxt = need_init;
                off_nxt = '0;
                mem_ctl.re = 1'b1;
                state_nxt = ST_ACHK;
              end
            end
            ffha_pkg::CMD_FREE: begin
              if (cmd.address == 32'd0) begin
                res_fail_nxt = 1'b0;
              end else if (!free_bad) begin
                mem_ctl.free_we = 1'b1;
                mem_waddr = off33[IDX_W+GSH-1:GSH];
                mem_wfree = 1'b1;
                state_nxt = ST_FSTART;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_ACHK: begin
        if (fit) begin
          split_nxt = do_split;
          if (do_split) begin
            mem_ctl.size_we = 1'b1;
            mem_ctl.free_we = 1'b1;
            mem_waddr = nb_a[IDX_W+GSH-1:GSH];
            mem_wsize = OFF_W'(sz_a - need_a - AW'(HDR));
            mem_wfree = 1'b1;
          end
          state_nxt = ST_ATAKE;
        end else if (end_a >= ue_a) begin
          state_nxt = ST_DONE;
        end else begin
          off_nxt = OFF_W'(end_a);
          mem_ctl.re = 1'b1;
          mem_raddr = end_a[IDX_W+GSH-1:GSH];
        end
      end
      ST_ATAKE: begin
        mem_ctl.size_we = split_r;
        mem_ctl.free_we = 1'b1;
        mem_waddr = off_r[IDX_W+GSH-1:GSH];
        mem_wsize = OFF_W'(need_a);
        mem_wfree = 1'b0;
        res_addr_nxt = abase_r + 32'(off_r) + 32'(HDR);
        res_fail_nxt = 1'b0;
        state_nxt = ST_DONE;
      end
      ST_FSTART: begin
        mem_ctl.re = 1'b1;
        state_nxt = ST_FCUR;
      end
      ST_FCUR: begin
        cur_nxt = '0;
        cur_size_nxt = rd_size;
        cur_free_nxt = rd_free;
        if (f1_a >= ue_a) begin
          res_fail_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          nxt_nxt = OFF_W'(f1_a);
          mem_ctl.re = 1'b1;
          mem_raddr = f1_a[IDX_W+GSH-1:GSH];
          state_nxt = ST_FNXT;
        end
      end
      ST_FNXT: begin
        if (cur_free_r && rd_free) begin
          mem_ctl.size_we = 1'b1;
          mem_waddr = cur_r[IDX_W+GSH-1:GSH];
          mem_wsize = OFF_W'(merge_a);
          cur_size_nxt = OFF_W'(merge_a);
        end else begin
          cur_nxt = nxt_r;
          cur_size_nxt = rd_size;
          cur_free_nxt = rd_free;
        end
        if (n2_a >= ue_a) begin
          res_fail_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          nxt_nxt = OFF_W'(n2_a);
          mem_ctl.re = 1'b1;
          mem_raddr = n2_a[IDX_W+GSH-1:GSH];
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
      abase_r <= 32'd0;
      ue_r <= '0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      abase_r <= abase_nxt;
      ue_r <= ue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    need_r <= need_nxt;
    split_r <= split_nxt;
    cur_r <= cur_nxt;
    cur_size_r <= cur_size_nxt;
    cur_free_r <= cur_free_nxt;
    nxt_r <= nxt_nxt;
    res_addr_r <= res_addr_nxt;
    res_fail_r <= res_fail_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res.result_address = res_addr_r;
  assign res.status = res_fail_r;

endmodule
`default_nettype wire

// File: design/first_fit_heap_allocator.sv
// Init and zero-address or rejected commands go straight from idle to the done state and the
// output register; allocate reads block headers in order until one fits, then claims it, and
// free marks its block free, then rereads the headers from the start, merging free neighbours.
// Throughput: one command at a time, one header read per cycle through the header memory port.
// Reset is synchronous and active low; it clears the configuration registers and the ready
// state, and leaves the header memory uncleared since no entry is read before it is written.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire ffha_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output ffha_pkg::out_item_t out_data,
  input wire logic cfg_we,
  input wire logic [0:0] cfg_index,
  input wire logic [31:0] cfg_wdata
);

  localparam int DEPTH = (HEAP_BYTES + ffha_pkg::GRAN - 1) / ffha_pkg::GRAN;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int OFF_W = $clog2(HEAP_BYTES + 1);

  logic [31:0] heap_base_r;
  logic [16:0] heap_bytes_r;
  logic out_valid_r;
  ffha_pkg::out_item_t out_data_r;

  logic busy, res_valid, res_take;
  ffha_pkg::out_item_t res;
  ffha_pkg::mem_ctl_t mem_ctl;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  logic [OFF_W-1:0] mem_wsize, rd_size;
  logic mem_wfree, rd_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= 32'd0;
      heap_bytes_r <= 17'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffha_pkg::CFG_HEAP_BASE: heap_base_r <= cfg_wdata;
        ffha_pkg::CFG_HEAP_BYTES: heap_bytes_r <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  ffha_engine #(.HEAP_BYTES(HEAP_BYTES)) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .heap_base(heap_base_r),
    .heap_bytes(heap_bytes_r),
    .cmd_valid(in_valid),
    .cmd(in_data),
    .busy(busy),
    .res_valid(res_valid),
    .res(res),
    .res_take(res_take),
    .mem_ctl(mem_ctl),
    .mem_raddr(mem_raddr),
    .mem_waddr(mem_waddr),
    .mem_wsize(mem_wsize),
    .mem_wfree(mem_wfree),
    .rd_size(rd_size),
    .rd_free(rd_free)
  );

  ffha_hdr_mem #(.HEAP_BYTES(HEAP_BYTES)) u_hdr_mem (
    .clk(clk),
    .ctl(mem_ctl),
    .raddr(mem_raddr),
    .waddr(mem_waddr),
    .wsize(mem_wsize),
    .wfree(mem_wfree),
    .rd_size(rd_size),
    .rd_free(rd_free)
  );

  assign in_stall = busy;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ffha_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffha_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = ffha_pkg::CFG_HEAP_BASE;
  logic [31:0] cfg_wdata = '0;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  ffha_pkg::in_item_t pending_cmds[$];
  ffha_pkg::out_item_t awaited_results[$];
  int unsigned granted_offs[$];
  int error_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int quiet_cycles = 0;
  int allocs_ok = 0;
  int frees_ok = 0;
  int inits_ok = 0;

  // Shadow heap state.
  logic [31:0] sh_base = '0;
  logic [16:0] sh_bytes = '0;
  bit sh_ready = 1'b0;
  longint unsigned sh_abase = 0;
  longint unsigned sh_uend = 0;
  longint unsigned blk_size[longint unsigned];
  bit blk_free[longint unsigned];

  function automatic logic shadow_setup();
    longint unsigned b, n, ab;
    b = sh_base;
    n = sh_bytes;
    if (b == 0 || n <= ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES || n > 65536)
      return 1'b1;
    if (b + n > 64'h1_0000_0000) return 1'b1;
    ab = ((b + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES) * ffha_pkg::ALIGN_BYTES;
    if (ab - b + ffha_pkg::HEADER_BYTES > n) return 1'b1;
    sh_abase = ab;
    sh_uend = n - (ab - b);
    blk_size[0] = sh_uend - ffha_pkg::HEADER_BYTES;
    blk_free[0] = 1'b1;
    sh_ready = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [31:0] heap_alloc(logic [15:0] req);
    longint unsigned need, off, sz, nb;
    if (!sh_ready || req == 0) return '0;
    need = ((longint'(req) + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES) *
           ffha_pkg::ALIGN_BYTES;
    off = 0;
    while (off < sh_uend) begin
      sz = blk_size[off];
      if (blk_free[off] && sz >= need) begin
        if (sz >= need + ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES) begin
          nb = off + ffha_pkg::HEADER_BYTES + need;
          if (nb < sh_uend) begin
            blk_size[nb] = sz - need - ffha_pkg::HEADER_BYTES;
            blk_free[nb] = 1'b1;
            blk_size[off] = need;
          end
        end
        blk_free[off] = 1'b0;
        return 32'(sh_abase + off + ffha_pkg::HEADER_BYTES);
      end
      if (off + ffha_pkg::HEADER_BYTES + sz >= sh_uend) break;
      off = off + ffha_pkg::HEADER_BYTES + sz;
    end
    return '0;
  endfunction

  function automatic logic heap_free(logic [31:0] addr);
    longint unsigned lo, off, cur, nxt;
    if (addr == 0) return 1'b0;
    if (!sh_ready) return 1'b1;
    lo = sh_abase + ffha_pkg::HEADER_BYTES;
    if (longint'(addr) < lo) return 1'b1;
    off = longint'(addr) - lo;
    if (off + ffha_pkg::HEADER_BYTES > sh_uend) return 1'b1;
    blk_free[off] = 1'b1;
    cur = 0;
    while (cur < sh_uend) begin
      nxt = cur + ffha_pkg::HEADER_BYTES + blk_size[cur];
      if (nxt >= sh_uend) break;
      if (blk_free[cur] && blk_free[nxt]) begin
        blk_size[cur] = blk_size[cur] + ffha_pkg::HEADER_BYTES + blk_size[nxt];
        continue;
      end
      cur = nxt;
    end
    return 1'b0;
  endfunction

  task automatic issue(logic [1:0] cmd, logic [15:0] req, logic [31:0] addr);
    ffha_pkg::in_item_t it;
    ffha_pkg::out_item_t res;
    it.command = cmd;
    it.request_bytes = req;
    it.address = addr;
    res = '0;
    res.status = 1'b1;
    case (cmd)
      ffha_pkg::CMD_INIT: begin
        res.status = shadow_setup();
        if (!res.status) begin
          granted_offs.delete();
          inits_ok++;
        end
      end
      ffha_pkg::CMD_ALLOC: begin
        res.result_address = heap_alloc(req);
        res.status = (res.result_address == 0);
        if (!res.status) begin
          granted_offs.push_back(
            32'(longint'(res.result_address) - sh_abase - ffha_pkg::HEADER_BYTES));
          allocs_ok++;
        end
      end
      ffha_pkg::CMD_FREE: begin
        res.status = heap_free(addr);
        if (!res.status && addr != 0) frees_ok++;
      end
      default: ;
    endcase
    pending_cmds.push_back(it);
    awaited_results.push_back(res);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && awaited_results.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == ffha_pkg::CFG_HEAP_BASE) sh_base = val;
    else sh_bytes = val[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] bytes);
    drain();
    write_reg(ffha_pkg::CFG_HEAP_BASE, base);
    write_reg(ffha_pkg::CFG_HEAP_BYTES, bytes);
  endtask

  // Frees a granted block, a zero address, one outside the region, or any before init.
  task automatic issue_free();
    int pick, k;
    longint unsigned a;
    pick = $urandom_range(0, 99);
    if (!sh_ready) begin
      issue(ffha_pkg::CMD_FREE, 16'($urandom), $urandom);
    end else if (pick < 80 && granted_offs.size() > 0) begin
      k = $urandom_range(0, granted_offs.size() - 1);
      a = sh_abase + ffha_pkg::HEADER_BYTES + granted_offs[k];
      if ($urandom_range(0, 9) < 8) granted_offs.delete(k);
      if (a >= 64'h1_0000_0000 || granted_offs.size() > 10000) a = 0;
      issue(ffha_pkg::CMD_FREE, 16'($urandom), 32'(a));
    end else if (pick < 86) begin
      issue(ffha_pkg::CMD_FREE, 16'($urandom), '0);
    end else if (pick < 93) begin
      a = sh_abase + $urandom_range(0, ffha_pkg::HEADER_BYTES - 1);
      issue(ffha_pkg::CMD_FREE, 16'($urandom), 32'(a));
    end else begin
      a = sh_abase + sh_uend + $urandom_range(1, 4000);
      if (a >= 64'h1_0000_0000) a = sh_abase + $urandom_range(0, ffha_pkg::HEADER_BYTES - 1);
      issue(ffha_pkg::CMD_FREE, 16'($urandom), 32'(a));
    end
  endtask

  task automatic issue_alloc();
    int pick;
    logic [15:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 5) req = '0;
    else if (pick < 12) req = 16'($urandom);
    else req = 16'($urandom_range(1, (sh_bytes > 64) ? sh_bytes / 6 : 16));
    issue(ffha_pkg::CMD_ALLOC, req, $urandom);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) beats_in++;
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch on result beat %0d: %s got %h expected %h", beats_out, what, got, want);
  endtask

  always @(posedge clk) begin
    ffha_pkg::out_item_t want;
    out_stall <= rst_n && ($urandom_range(0, 99) < rcv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report("unexpected beat", out_data.result_address, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_address !== want.result_address)
          report("result_address", out_data.result_address, want.result_address);
        if (out_data.status !== want.status)
          report("status", 32'(out_data.status), 32'(want.status));
      end
      beats_out++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", awaited_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int phase, n, pick;
    logic [31:0] base, bytes;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: commands before any init, rejected inits, then a tiny heap and a full-size one.
    issue(ffha_pkg::CMD_ALLOC, 16'd8, 32'hFFFF_FFFF);
    issue(ffha_pkg::CMD_FREE, 16'hFFFF, '0);
    issue(ffha_pkg::CMD_FREE, '0, 32'hDEAD_BEEF);
    issue(CMD_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'd0, 32'd1000);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'd64, 32'd20);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'd64, 32'd65537);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'hFFFF_FFF0, 32'h0001_FFFF);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'hFFFF_FFC0, 32'd65);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    set_heap(32'd1, 32'd21);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    issue(ffha_pkg::CMD_ALLOC, 16'd0, '0);
    issue(ffha_pkg::CMD_ALLOC, 16'd1, '0);
    set_heap(32'hFFFF_0000, 32'd65536);
    issue(ffha_pkg::CMD_INIT, '0, '0);
    issue(ffha_pkg::CMD_ALLOC, 16'hFFFF, '0);
    issue(ffha_pkg::CMD_ALLOC, 16'd65512, '0);
    issue(ffha_pkg::CMD_ALLOC, 16'd1, '0);
    issue(ffha_pkg::CMD_FREE, '0, 32'hFFFF_000C);
    issue(ffha_pkg::CMD_FREE, '0, 32'hFFFF_000C);
    issue(ffha_pkg::CMD_FREE, '0, 32'hFFFF_0003);
    issue(ffha_pkg::CMD_ALLOC, 16'd65516, '0);
    issue(CMD_UNKNOWN, '0, '0);

    n = 0;
    phase = 0;
    while (n < 1330) begin
      case (phase % 5)
        1: begin snd_idle_pct = 46; rcv_stall_pct = 0; end
        2: begin snd_idle_pct = 0; rcv_stall_pct = 46; end
        3: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      pick = $urandom_range(0, 15);
      bytes = (pick == 0) ? 32'd65536 : (pick == 1) ? $urandom : $urandom_range(21, 1500);
      base = $urandom;
      if (pick == 2) base = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else if (64'(base) + bytes[16:0] > 64'h1_0000_0000) base = base - 32'h0002_0000;
      set_heap(base, bytes);
      issue(ffha_pkg::CMD_INIT, '0, $urandom);
      n++;
      repeat ($urandom_range(30, 70)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) issue_alloc();
        else if (pick < 95) issue_free();
        else if (pick < 97) issue(CMD_UNKNOWN, 16'($urandom), $urandom);
        else issue(ffha_pkg::CMD_INIT, 16'($urandom), $urandom);
        n++;
        if (phase == 3 && n % 40 == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d command beats over %0d heap settings with four stall mixes;",
             beats_in, phase + 7);
    $display("%0d inits, %0d grants and %0d frees succeeded", inits_ok, allocs_ok, frees_ok);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
